>>> rtl/fsk_mod_pkg.sv
// Shared types and constants for the FSK tone frame modulator.
`default_nettype none

package fsk_mod_pkg;

   localparam int SAMPLE_RATE_DEFAULT = 8000;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int FREQ_W   = 12;   // tone frequency and tone length registers
   localparam int SAMPLE_W = 16;   // PCM output field
   localparam int ACTION_W = 2;
   localparam int BYTE_W   = 8;
   localparam int TONE_W   = 4;    // sixteen tones per byte

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [FREQ_W-1:0] START_HZ_RST     = 12'd2000;
   localparam logic [FREQ_W-1:0] ONE_HZ_RST       = 12'd600;
   localparam logic [FREQ_W-1:0] ZERO_HZ_RST      = 12'd800;
   localparam logic [FREQ_W-1:0] SEPARATOR_HZ_RST = 12'd1200;
   localparam logic [FREQ_W-1:0] END_HZ_RST       = 12'd1500;
   localparam logic [FREQ_W-1:0] SPT_RST          = 12'd400;

   localparam logic [TONE_W-1:0] LAST_TONE = 4'd15;

   // pi/2 in Q60
   localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_BEGIN = 2'd1,
      ACT_BYTE  = 2'd2,
      ACT_END   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_START = 2'd1,
      MODE_BYTE  = 2'd2,
      MODE_END   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_START_HZ     = 3'd0,
      CSR_ONE_HZ       = 3'd1,
      CSR_ZERO_HZ      = 3'd2,
      CSR_SEPARATOR_HZ = 3'd3,
      CSR_END_HZ       = 3'd4,
      CSR_SPT          = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

>>> rtl/fsk_tone_frame_modulator.sv
// FSK tone frame modulator: one PCM sample per request, tone framing, sine ROM.
// A request transfer reaches its response through the ROM read register, then
// the output register; one request per cycle while the output is not stalled.
// The input side stalls only while both the ROM stage and the output register
// hold samples and the output side is stalled.
// Synchronous reset returns registers to their defaults and the framer to idle;
// the sine ROM is constant, so no clearing pass follows reset.
`default_nettype none

module fsk_tone_frame_modulator
   import fsk_mod_pkg::*;
#(
   parameter int SAMPLE_RATE = SAMPLE_RATE_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ACTION_W-1:0]          req_action,
   input  wire logic [BYTE_W-1:0]            req_data_byte,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]        rsp_sample,
   output logic                              rsp_tone_active,
   output logic                              rsp_accepted,
   output logic                              rsp_ready_res,

   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [CSR_ADDR_W-1:0]        paddr,
   input  wire logic [CSR_DATA_W-1:0]        pwdata,
   output logic [CSR_DATA_W-1:0]             prdata,
   output logic                              pready
);

   // ------------------------------------------------------------------
   // Derived sizes
   // ------------------------------------------------------------------
   localparam int PHASE_W   = $clog2(SAMPLE_RATE);
   // The folded angle index only takes even values of 4*phase, so the
   // quarter wave needs rate/2 + 1 entries.
   localparam int ROM_DEPTH = SAMPLE_RATE / 2 + 1;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   // Subtractions needed to bring any 12-bit frequency below the rate.
   localparam int FOLD_STEPS = ((1 << FREQ_W) - 1) / SAMPLE_RATE;

   localparam logic [PHASE_W:0] RATE_X = (PHASE_W+1)'(SAMPLE_RATE);

   localparam logic [PHASE_W-1:0] STEP_START_RST = PHASE_W'(START_HZ_RST % SAMPLE_RATE);
   localparam logic [PHASE_W-1:0] STEP_ONE_RST   = PHASE_W'(ONE_HZ_RST % SAMPLE_RATE);
   localparam logic [PHASE_W-1:0] STEP_ZERO_RST  = PHASE_W'(ZERO_HZ_RST % SAMPLE_RATE);
   localparam logic [PHASE_W-1:0] STEP_SEP_RST   = PHASE_W'(SEPARATOR_HZ_RST % SAMPLE_RATE);
   localparam logic [PHASE_W-1:0] STEP_END_RST   = PHASE_W'(END_HZ_RST % SAMPLE_RATE);

   typedef logic [SAMPLE_W-1:0] rom_type [ROM_DEPTH];

   // ------------------------------------------------------------------
   // Sine ROM contents, built at elaboration.
   // Entry u holds the low bits of round(A*sin(pi*u/rate)), evaluated with
   // a Q60 Taylor series, A = 2^(SAMPLE_BITS-1)-1, half rounded up.
   // ------------------------------------------------------------------
   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return prod[123:60];
   endfunction

   function automatic rom_type build_rom();
      rom_type     t;
      logic [63:0] s, x, x2, term, sum, amp, val;
      amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
      for (int u = 0; u < ROM_DEPTH; u++) begin
         s    = 64'(2 * u);
         x    = (HALF_PI_Q60 / SAMPLE_RATE) * s + ((HALF_PI_Q60 % SAMPLE_RATE) * s) / SAMPLE_RATE;
         x2   = mul_q60(x, x);
         term = x;
         sum  = x;
         term = mul_q60(term, x2) / 64'd6;   sum = sum - term;
         term = mul_q60(term, x2) / 64'd20;  sum = sum + term;
         term = mul_q60(term, x2) / 64'd42;  sum = sum - term;
         term = mul_q60(term, x2) / 64'd72;  sum = sum + term;
         term = mul_q60(term, x2) / 64'd110; sum = sum - term;
         term = mul_q60(term, x2) / 64'd156; sum = sum + term;
         term = mul_q60(term, x2) / 64'd210; sum = sum - term;
         term = mul_q60(term, x2) / 64'd272; sum = sum + term;
         term = mul_q60(term, x2) / 64'd342; sum = sum - term;
         term = mul_q60(term, x2) / 64'd420; sum = sum + term;
         term = mul_q60(term, x2) / 64'd506; sum = sum - term;
         term = mul_q60(term, x2) / 64'd600; sum = sum + term;
         val  = (((sum >> 20) * amp) + (64'd1 << 39)) >> 40;
         t[u] = val[SAMPLE_W-1:0];
      end
      return t;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Frequency reduced modulo the sample rate: FOLD_STEPS compare-subtracts.
   function automatic logic [PHASE_W-1:0] fold_freq(input logic [FREQ_W-1:0] f);
      logic [FREQ_W-1:0] v;
      v = f;
      for (int i = 0; i < FOLD_STEPS; i++) begin
         if (32'(v) >= SAMPLE_RATE) begin
            v = v - FREQ_W'(SAMPLE_RATE);
         end
      end
      return PHASE_W'(v);
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers. Raw values read back; phase steps are kept
   // pre-reduced so the sample path only adds and wraps once.
   // ------------------------------------------------------------------
   logic [FREQ_W-1:0]  start_hz_ff, one_hz_ff, zero_hz_ff, sep_hz_ff, end_hz_ff, spt_ff;
   logic [PHASE_W-1:0] step_start_ff, step_one_ff, step_zero_ff, step_sep_ff, step_end_ff;
   logic               csr_write;
   csr_index_type      csr_sel;
   logic [FREQ_W-1:0]  csr_wval;
   logic [PHASE_W-1:0] csr_wstep;
   logic [FREQ_W-1:0]  csr_rval;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_sel   = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_wval  = pwdata[FREQ_W-1:0];
   assign csr_wstep = fold_freq(csr_wval);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hz_ff   <= START_HZ_RST;
         one_hz_ff     <= ONE_HZ_RST;
         zero_hz_ff    <= ZERO_HZ_RST;
         sep_hz_ff     <= SEPARATOR_HZ_RST;
         end_hz_ff     <= END_HZ_RST;
         spt_ff        <= SPT_RST;
         step_start_ff <= STEP_START_RST;
         step_one_ff   <= STEP_ONE_RST;
         step_zero_ff  <= STEP_ZERO_RST;
         step_sep_ff   <= STEP_SEP_RST;
         step_end_ff   <= STEP_END_RST;
      end else if (csr_write) begin
         case (csr_sel)
            CSR_START_HZ: begin
               start_hz_ff   <= csr_wval;
               step_start_ff <= csr_wstep;
            end
            CSR_ONE_HZ: begin
               one_hz_ff   <= csr_wval;
               step_one_ff <= csr_wstep;
            end
            CSR_ZERO_HZ: begin
               zero_hz_ff   <= csr_wval;
               step_zero_ff <= csr_wstep;
            end
            CSR_SEPARATOR_HZ: begin
               sep_hz_ff   <= csr_wval;
               step_sep_ff <= csr_wstep;
            end
            CSR_END_HZ: begin
               end_hz_ff   <= csr_wval;
               step_end_ff <= csr_wstep;
            end
            CSR_SPT: begin
               spt_ff <= csr_wval;
            end
            default: ;  // unmapped, write dropped
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_START_HZ:     csr_rval = start_hz_ff;
         CSR_ONE_HZ:       csr_rval = one_hz_ff;
         CSR_ZERO_HZ:      csr_rval = zero_hz_ff;
         CSR_SEPARATOR_HZ: csr_rval = sep_hz_ff;
         CSR_END_HZ:       csr_rval = end_hz_ff;
         CSR_SPT:          csr_rval = spt_ff;
         default:          csr_rval = '0;
      endcase
   end

   assign prdata = {{(CSR_DATA_W-FREQ_W){1'b0}}, csr_rval};

   // ------------------------------------------------------------------
   // Handshake.
   // Two result slots: the ROM stage (s1) and the output register. The ROM
   // stage moves on whenever the output register is free or being emptied.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_advance;
   logic req_accept;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Tone framer state
   // ------------------------------------------------------------------
   mode_type           mode_ff, mode_in, mode_cur;
   logic [TONE_W-1:0]  tone_index_ff, tone_index_in, tone_cur;
   logic [FREQ_W-1:0]  sample_count_ff, sample_count_in, count_cur, count_inc, spt_eff;
   logic [PHASE_W-1:0] phase_ff, phase_in, phase_cur, step, phase_adv;
   logic [BYTE_W-1:0]  held_byte_ff, held_byte_in, byte_cur;
   logic [PHASE_W:0]   phase_sum, phase_dbl, fold;
   logic [PHASE_W+1:0] fold_dbl;
   logic [ROM_AW-1:0]  rom_addr;
   logic               offer_taken, tone_on, sine_neg;

   always_comb begin
      // An offer opens a new tone only while idle; its first sample goes
      // out on the same transfer.
      offer_taken = (mode_ff == MODE_IDLE) && (action_type'(req_action) != ACT_TICK);
      mode_cur    = mode_ff;
      tone_cur    = tone_index_ff;
      count_cur   = sample_count_ff;
      phase_cur   = phase_ff;
      byte_cur    = held_byte_ff;
      if (offer_taken) begin
         case (action_type'(req_action))
            ACT_BEGIN: mode_cur = MODE_START;
            ACT_BYTE:  mode_cur = MODE_BYTE;
            ACT_END:   mode_cur = MODE_END;
            default:   mode_cur = MODE_IDLE;
         endcase
         tone_cur  = '0;
         count_cur = '0;
         phase_cur = '0;
         if (action_type'(req_action) == ACT_BYTE) begin
            byte_cur = req_data_byte;
         end
      end
      tone_on = (mode_cur != MODE_IDLE);

      // Odd tones are separators; even tones carry the bits MSB first.
      case (mode_cur)
         MODE_START: step = step_start_ff;
         MODE_END:   step = step_end_ff;
         default: begin
            if (tone_cur[0]) begin
               step = step_sep_ff;
            end else if (byte_cur[~tone_cur[TONE_W-1:1]]) begin
               step = step_one_ff;
            end else begin
               step = step_zero_ff;
            end
         end
      endcase

      phase_sum = {1'b0, phase_cur} + {1'b0, step};
      if (phase_sum >= RATE_X) begin
         phase_adv = PHASE_W'(phase_sum - RATE_X);
      end else begin
         phase_adv = phase_sum[PHASE_W-1:0];
      end

      count_inc = count_cur + 1'b1;
      spt_eff   = (spt_ff == '0) ? FREQ_W'(1) : spt_ff;

      mode_in         = mode_cur;
      tone_index_in   = tone_cur;
      sample_count_in = count_cur;
      phase_in        = phase_cur;
      held_byte_in    = byte_cur;
      if (tone_on) begin
         sample_count_in = count_inc;
         phase_in        = phase_adv;
         if (count_inc >= spt_eff) begin
            // tone done: next tone restarts at phase zero
            sample_count_in = '0;
            phase_in        = '0;
            if ((mode_cur == MODE_BYTE) && (tone_cur != LAST_TONE)) begin
               tone_index_in = tone_cur + 1'b1;
            end else begin
               mode_in       = MODE_IDLE;
               tone_index_in = '0;
            end
         end
      end

      // Quarter-wave fold: 2*phase against the rate gives the half,
      // then mirror about the quarter point.
      phase_dbl = {phase_cur, 1'b0};
      sine_neg  = (phase_dbl >= RATE_X);
      fold      = sine_neg ? (phase_dbl - RATE_X) : phase_dbl;
      fold_dbl  = {fold, 1'b0};
      if (fold_dbl > {1'b0, RATE_X}) begin
         rom_addr = ROM_AW'(RATE_X - fold);
      end else begin
         rom_addr = ROM_AW'(fold);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         tone_index_ff   <= '0;
         sample_count_ff <= '0;
         phase_ff        <= '0;
         held_byte_ff    <= '0;
      end else if (req_accept) begin
         mode_ff         <= mode_in;
         tone_index_ff   <= tone_index_in;
         sample_count_ff <= sample_count_in;
         phase_ff        <= phase_in;
         held_byte_ff    <= held_byte_in;
      end
   end

   // ------------------------------------------------------------------
   // ROM stage: registered read plus the flags that travel with it
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] rom_data_ff;
   logic                s1_neg_ff, s1_active_ff, s1_accepted_ff, s1_ready_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rom_data_ff    <= SINE_ROM[rom_addr];
         s1_neg_ff      <= sine_neg;
         s1_active_ff   <= tone_on;
         s1_accepted_ff <= offer_taken;
         s1_ready_ff    <= (mode_in == MODE_IDLE);
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic [SAMPLE_W-1:0] sample_in, rsp_sample_ff;
   logic                rsp_active_ff, rsp_accepted_ff, rsp_ready_ff;

   always_comb begin
      if (!s1_active_ff) begin
         sample_in = '0;              // silence between messages
      end else if (s1_neg_ff) begin
         sample_in = '0 - rom_data_ff;
      end else begin
         sample_in = rom_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_sample_ff   <= sample_in;
         rsp_active_ff   <= s1_active_ff;
         rsp_accepted_ff <= s1_accepted_ff;
         rsp_ready_ff    <= s1_ready_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = $signed(rsp_sample_ff);
   assign rsp_tone_active = rsp_active_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_ready_res   = rsp_ready_ff;

endmodule

`default_nettype wire

>>> dv/fsk_tone_frame_checker.sv
// Checker for the FSK tone frame modulator: predicts each PCM sample and compares responses.
`default_nettype none

module fsk_tone_frame_checker
   import fsk_mod_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [ACTION_W-1:0]   req_action,
   input  wire logic [BYTE_W-1:0]     req_data_byte,

   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic signed [SAMPLE_W-1:0] rsp_sample,
   input  wire logic                  rsp_tone_active,
   input  wire logic                  rsp_accepted,
   input  wire logic                  rsp_ready_res,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   input  wire logic [CSR_DATA_W-1:0] prdata,
   input  wire logic                  pready,

   output int                         fail_count,
   output int                         samples_due,
   output int                         samples_checked,
   output int                         offers_taken,
   output int                         offers_ignored
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PHASE_MOD  = SAMPLE_RATE_DEFAULT;
   localparam logic [63:0] RATE_Q     = 64'(SAMPLE_RATE_DEFAULT);
   localparam logic [63:0] QUARTER_PI = 64'h1921FB54442D1847;   // pi/2, Q60
   localparam logic [63:0] PEAK       = (64'd1 << (SAMPLE_BITS_DEFAULT - 1)) - 64'd1;
   localparam int          NUM_REGS   = 6;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       tone_active;
      logic                       accepted;
      logic                       ready_res;
   } pcm_tick_type;

   pcm_tick_type     pcm_due [$];
   int               sine_lut [PHASE_MOD];

   logic [FREQ_W-1:0] tone_reg [NUM_REGS];
   mode_type          tone_mode;
   logic [4:0]        tone_idx;
   logic [11:0]       tone_count;
   logic [12:0]       tone_phase;
   logic [7:0]        frame_byte;

   int fails, checked, taken, ignored;

   // (a*b) >> 60 on the full product
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return prod[123:60];
   endfunction

   // round(PEAK * sin(2*pi*p/rate)), half away from zero, via a Taylor series
   function automatic int sine_of(input int p);
      logic [63:0] s, x, x2, term, sum, mag;
      logic        neg;
      s   = 64'(p) * 64'd4;
      neg = 1'b0;
      if (s >= 64'd2 * RATE_Q) begin
         neg = 1'b1;
         s   = s - 64'd2 * RATE_Q;
      end
      if (s > RATE_Q)
         s = 64'd2 * RATE_Q - s;
      x    = (QUARTER_PI / RATE_Q) * s + ((QUARTER_PI % RATE_Q) * s) / RATE_Q;
      x2   = q60_mul(x, x);
      term = x;
      sum  = x;
      for (int k = 1; k <= 12; k++) begin
         term = q60_mul(term, x2) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1)
            sum = sum - term;
         else
            sum = sum + term;
      end
      mag = ((sum >> 20) * PEAK + (64'd1 << 39)) >> 40;
      return neg ? -int'(mag) : int'(mag);
   endfunction

   initial begin
      for (int p = 0; p < PHASE_MOD; p++)
         sine_lut[p] = sine_of(p);
   end

   // one sample tick of the framer
   function automatic pcm_tick_type next_pcm_tick(input action_type act, input logic [7:0] din);
      pcm_tick_type      r;
      logic [FREQ_W-1:0] hz;
      logic [11:0]       span;
      r = '0;
      if (tone_mode == MODE_IDLE && act != ACT_TICK) begin
         r.accepted = 1'b1;
         case (act)
            ACT_BEGIN: tone_mode = MODE_START;
            ACT_BYTE:  tone_mode = MODE_BYTE;
            default:   tone_mode = MODE_END;
         endcase
         tone_idx   = '0;
         tone_count = '0;
         tone_phase = '0;
         if (act == ACT_BYTE)
            frame_byte = din;
      end
      if (tone_mode != MODE_IDLE) begin
         r.tone_active = 1'b1;
         r.sample      = SAMPLE_W'(sine_lut[tone_phase]);
         case (tone_mode)
            MODE_START: hz = tone_reg[CSR_START_HZ];
            MODE_END:   hz = tone_reg[CSR_END_HZ];
            default:
               if (tone_idx[0])
                  hz = tone_reg[CSR_SEPARATOR_HZ];
               else if (frame_byte[3'd7 - tone_idx[3:1]])
                  hz = tone_reg[CSR_ONE_HZ];
               else
                  hz = tone_reg[CSR_ZERO_HZ];
         endcase
         tone_phase = 13'((int'(tone_phase) + int'(hz) % PHASE_MOD) % PHASE_MOD);
         span       = (tone_reg[CSR_SPT] == '0) ? 12'd1 : tone_reg[CSR_SPT];
         tone_count = tone_count + 12'd1;
         if (tone_count >= span) begin
            tone_count = '0;
            tone_phase = '0;
            if (tone_mode == MODE_BYTE && tone_idx < 5'd15)
               tone_idx = tone_idx + 5'd1;
            else begin
               tone_mode = MODE_IDLE;
               tone_idx  = '0;
            end
         end
      end
      r.ready_res = (tone_mode == MODE_IDLE);
      return r;
   endfunction

   always @(posedge clock) begin
      pcm_tick_type due;
      action_type   act;
      int           slot;
      if (reset) begin
         tone_reg[CSR_START_HZ]     = START_HZ_RST;
         tone_reg[CSR_ONE_HZ]       = ONE_HZ_RST;
         tone_reg[CSR_ZERO_HZ]      = ZERO_HZ_RST;
         tone_reg[CSR_SEPARATOR_HZ] = SEPARATOR_HZ_RST;
         tone_reg[CSR_END_HZ]       = END_HZ_RST;
         tone_reg[CSR_SPT]          = SPT_RST;
         tone_mode  = MODE_IDLE;
         tone_idx   = '0;
         tone_count = '0;
         tone_phase = '0;
         frame_byte = '0;
         pcm_due.delete();
      end else begin
         if (req_valid && !req_stall) begin
            act = action_type'(req_action);
            due = next_pcm_tick(act, req_data_byte);
            if (due.accepted)
               taken++;
            else if (act != ACT_TICK)
               ignored++;
            pcm_due.push_back(due);
         end

         if (rsp_valid && !rsp_stall) begin
            if (pcm_due.size() == 0) begin
               $error("response transfer with no sample expected");
               fails++;
            end else begin
               due = pcm_due.pop_front();
               checked++;
               if (rsp_sample !== due.sample) begin
                  $error("sample mismatch: expected %0d, got %0d", due.sample, rsp_sample);
                  fails++;
               end
               if (rsp_tone_active !== due.tone_active) begin
                  $error("tone_active mismatch: expected %0b, got %0b",
                         due.tone_active, rsp_tone_active);
                  fails++;
               end
               if (rsp_accepted !== due.accepted) begin
                  $error("accepted mismatch: expected %0b, got %0b", due.accepted, rsp_accepted);
                  fails++;
               end
               if (rsp_ready_res !== due.ready_res) begin
                  $error("ready_res mismatch: expected %0b, got %0b",
                         due.ready_res, rsp_ready_res);
                  fails++;
               end
            end
         end

         // register port: writes land after this tick's sample, reads compared as they go
         if (psel && penable && pready) begin
            slot = int'(paddr[CSR_ADDR_W-1:2]);
            if (slot < NUM_REGS) begin
               if (pwrite)
                  tone_reg[slot] = pwdata[FREQ_W-1:0];
               else if (prdata !== CSR_DATA_W'(tone_reg[slot])) begin
                  $error("prdata mismatch at register %0d: expected %0d, got %0d",
                         slot, tone_reg[slot], prdata);
                  fails++;
               end
            end
         end
      end

      fail_count      <= fails;
      samples_due     <= pcm_due.size();
      samples_checked <= checked;
      offers_taken    <= taken;
      offers_ignored  <= ignored;
   end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench top for the FSK tone frame modulator: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top
   import fsk_mod_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES   = 300;        // long receiver hold-off
   localparam int DRAIN_LIMIT   = 5000;       // cycles allowed for the response side to empty
   localparam int SETTLE_CYCLES = 8;          // two-stage pipeline plus margin
   localparam int RUN_LIMIT_NS  = 4_000_000;  // far beyond the slowest clean run
   localparam int PHASE_ITEMS   = 60;

   logic clock;
   logic reset = 1'b1;

   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic [ACTION_W-1:0]          req_action    = '0;
   logic [BYTE_W-1:0]            req_data_byte = '0;

   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_sample;
   logic                         rsp_tone_active;
   logic                         rsp_accepted;
   logic                         rsp_ready_res;

   logic                         psel    = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]        paddr   = '0;
   logic [CSR_DATA_W-1:0]        pwdata  = '0;
   logic [CSR_DATA_W-1:0]        prdata;
   logic                         pready;

   int fail_count, samples_due, samples_checked, offers_taken, offers_ignored;

   int                gap_pct   = 0;      // chance per cycle that the sender idles
   int                stall_pct = 0;      // chance per cycle that the receiver stalls
   bit                hold_req  = 1'b0;   // ask the stall process for one long hold-off
   bit                drain_late = 1'b0;
   int                items_sent = 0;
   logic [FREQ_W-1:0] spt_now = SPT_RST;  // tone length as programmed, for the schedule

   fsk_tone_frame_modulator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_tone_active (rsp_tone_active),
      .rsp_accepted    (rsp_accepted),
      .rsp_ready_res   (rsp_ready_res),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   fsk_tone_frame_checker sample_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sample      (rsp_sample),
      .rsp_tone_active (rsp_tone_active),
      .rsp_accepted    (rsp_accepted),
      .rsp_ready_res   (rsp_ready_res),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .samples_due     (samples_due),
      .samples_checked (samples_checked),
      .offers_taken    (offers_taken),
      .offers_ignored  (offers_ignored)
   );

   // 50 MHz
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // hard stop in case a handshake never completes
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   // Receiver side. Random stalls at stall_pct; on request one unbroken hold-off of
   // HOLD_CYCLES, counted here, so the pipeline fills and the block stalls its input.
   initial begin : rsp_stall_drive
      int held;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_stall <= 1'b1;
            for (held = 1; held < HOLD_CYCLES; held++)
               @(posedge clock);
            hold_req = 1'b0;
         end else
            rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Register port access: setup, access, then one idle cycle so that back-to-back
   // accesses never assign psel twice in one step. pready is waited on, not assumed.
   task automatic csr_access(input bit wr, input csr_index_type idx,
                             input logic [FREQ_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      // upper bits are junk the block must drop
      pwdata  <= ($urandom() & 32'hFFFF_F000) | CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (wr && idx == CSR_SPT)
         spt_now = value;
   endtask

   // all six registers, then read them back
   task automatic program_tones(input logic [FREQ_W-1:0] start_hz, one_hz, zero_hz,
                                input logic [FREQ_W-1:0] sep_hz, end_hz, span);
      csr_access(1'b1, CSR_START_HZ, start_hz);
      csr_access(1'b1, CSR_ONE_HZ, one_hz);
      csr_access(1'b1, CSR_ZERO_HZ, zero_hz);
      csr_access(1'b1, CSR_SEPARATOR_HZ, sep_hz);
      csr_access(1'b1, CSR_END_HZ, end_hz);
      csr_access(1'b1, CSR_SPT, span);
      for (int r = 0; r < 6; r++)
         csr_access(1'b0, csr_index_type'(r), '0);
   endtask

   // One request transfer. Idle cycles come first, so valid is only ever lowered
   // in a step where it is not also raised.
   task automatic send_tick(input action_type act, input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom());
      endcase
   endfunction

   // Offer an action to an idle block and play out whatever it starts. Every tick is
   // one sample, so the busy span is known exactly from spt_now; ticks inside it carry
   // stray offers now and then, which the block must ignore.
   task automatic play_action(input action_type act, input logic [BYTE_W-1:0] b);
      int span;
      int n;
      if (act == ACT_TICK)
         span = 1;
      else
         span = ((spt_now == '0) ? 1 : int'(spt_now)) * ((act == ACT_BYTE) ? 16 : 1);
      send_tick(act, b);
      for (n = 1; n < span; n++)
         if ($urandom_range(99) < 20)
            send_tick(action_type'($urandom_range(3)), pick_byte());
         else
            send_tick(ACT_TICK, BYTE_W'($urandom()));
   endtask

   // Mostly well-formed frames (begin, bytes, end); the rest are broken frames and
   // loose offers at idle. Stops only at a frame boundary, so the block ends idle.
   task automatic run_frames(input int quota);
      int first;
      int k;
      int shape;
      first = items_sent;
      while (items_sent - first < quota) begin
         shape = $urandom_range(99);
         if (shape < 70) begin
            play_action(ACT_BEGIN, pick_byte());
            for (k = $urandom_range(1, 3); k > 0; k--)
               play_action(ACT_BYTE, pick_byte());
            play_action(ACT_END, pick_byte());
         end else if (shape < 85) begin
            case ($urandom_range(2))
               0: begin               // no opening tone
                  play_action(ACT_BYTE, pick_byte());
                  play_action(ACT_END, pick_byte());
               end
               1: begin               // begin again inside a frame, never closed
                  play_action(ACT_BEGIN, pick_byte());
                  play_action(ACT_BYTE, pick_byte());
                  play_action(ACT_BEGIN, pick_byte());
               end
               default: begin         // closing tone alone, then a stray byte
                  play_action(ACT_END, pick_byte());
                  play_action(ACT_BYTE, pick_byte());
               end
            endcase
         end else
            play_action(action_type'($urandom_range(3)), pick_byte());
         // idle ticks between frames
         for (k = $urandom_range(2); k > 0; k--)
            play_action(ACT_TICK, pick_byte());
      end
   endtask

   // Stop offering, wait for every expected sample, then let the pipeline settle.
   // The first edge makes sure the count includes the last transfer.
   task automatic wait_drained();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      @(posedge clock);
      while (samples_due != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (samples_due != 0)
         drain_late = 1'b1;
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int p;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values
      for (p = 0; p < 6; p++)
         csr_access(1'b0, csr_index_type'(p), '0);

      // Directed, reset tones with two samples per tone: silence at idle, start tone,
      // offers while busy, back-to-back begins, end tone without a frame.
      csr_access(1'b1, CSR_SPT, 12'd2);
      send_tick(ACT_TICK, 8'h00);
      send_tick(ACT_BEGIN, 8'hFF);
      send_tick(ACT_BYTE, 8'hFF);     // busy: ignored
      send_tick(ACT_END, 8'h00);
      send_tick(ACT_BEGIN, 8'h00);    // busy: ignored, tone ends here
      send_tick(ACT_BEGIN, 8'hAA);
      send_tick(ACT_TICK, 8'h55);
      send_tick(ACT_TICK, 8'h00);
      wait_drained();

      // Directed, zero frequency (silent but active) and the widest register value.
      csr_access(1'b1, CSR_START_HZ, 12'd0);
      csr_access(1'b1, CSR_END_HZ, 12'hFFF);
      csr_access(1'b1, CSR_SPT, 12'd3);
      play_action(ACT_BEGIN, 8'h00);
      play_action(ACT_END, 8'hFF);
      wait_drained();

      // Directed, tone length zero is one sample: byte 0xFF with every action
      // offered while it plays, then a lone end tone.
      csr_access(1'b1, CSR_ONE_HZ, 12'd1);
      csr_access(1'b1, CSR_ZERO_HZ, 12'd3999);
      csr_access(1'b1, CSR_SEPARATOR_HZ, 12'hFFF);
      csr_access(1'b1, CSR_SPT, 12'd0);
      send_tick(ACT_BYTE, 8'hFF);
      for (n = 1; n < 16; n++)
         send_tick(action_type'(n % 4), BYTE_W'(n * 17));
      send_tick(ACT_END, 8'h00);
      send_tick(ACT_TICK, 8'hFF);
      wait_drained();

      // Random phases: settings swept across reset values, extremes and random
      // values, idling cycled through none / sender / receiver / both.
      for (p = 0; p < 8; p++) begin
         case (p)
            0: program_tones(START_HZ_RST, ONE_HZ_RST, ZERO_HZ_RST, SEPARATOR_HZ_RST,
                             END_HZ_RST, 12'd2);
            1: program_tones(FREQ_W'($urandom()), FREQ_W'($urandom()), FREQ_W'($urandom()),
                             FREQ_W'($urandom()), FREQ_W'($urandom()), 12'd1);
            2: program_tones(12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd3);
            3: program_tones(12'd3999, 12'd3999, 12'd3999, 12'd3999, 12'd3999, 12'd4);
            4: program_tones(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'd2);
            default:
               program_tones(FREQ_W'($urandom_range(1, 3999)), FREQ_W'($urandom_range(1, 3999)),
                             FREQ_W'($urandom_range(1, 3999)), FREQ_W'($urandom_range(1, 3999)),
                             FREQ_W'($urandom_range(1, 3999)), FREQ_W'($urandom_range(1, 5)));
         endcase
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 50; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 50; end
            default: begin gap_pct = 10; stall_pct = 10; end
         endcase
         // back-pressure: the receiver holds off while the sender keeps offering
         if (p == 0)
            hold_req = 1'b1;
         run_frames(PHASE_ITEMS);
         wait_drained();
      end

      // Longest tone length: part of one start tone, stray offers ignored throughout.
      // Last phase, so the tone may still be playing when the run ends.
      program_tones(FREQ_W'($urandom_range(1, 3999)), FREQ_W'($urandom_range(1, 3999)),
                    FREQ_W'($urandom_range(1, 3999)), FREQ_W'($urandom_range(1, 3999)),
                    FREQ_W'($urandom_range(1, 3999)), 12'd4095);
      gap_pct   = 10;
      stall_pct = 10;
      send_tick(ACT_BEGIN, pick_byte());
      for (n = 0; n < 250; n++)
         send_tick(action_type'($urandom_range(3)), pick_byte());
      wait_drained();

      if (samples_due != 0)
         $error("%0d expected samples never arrived", samples_due);
      $display("Covered %0d sample ticks over 11 register settings: %0d offers taken, %0d ignored.",
               items_sent, offers_taken, offers_ignored);
      $display("%0d response transfers compared, including a %0d-cycle receiver hold-off.",
               samples_checked, HOLD_CYCLES);
      if (fail_count == 0 && samples_due == 0 && !drain_late)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

>>> fsk_tone_frame_modulator.f
rtl/fsk_mod_pkg.sv
rtl/fsk_tone_frame_modulator.sv
dv/fsk_tone_frame_checker.sv
dv/tb_top.sv
